@@ rtl/sbfd_pkg.sv @@
// ----------------------------------------------------------------------------
// sbfd_pkg
// Shared constants and types of the SBUS frame decoder.
// ----------------------------------------------------------------------------
package sbfd_pkg;

  localparam logic [7:0] START_BYTE   = 8'h0f;
  localparam int         FRAME_BYTES  = 25;
  localparam int         STORED_BYTES = FRAME_BYTES - 2;
  localparam int         FRAME_W      = STORED_BYTES * 8;
  localparam int         POS_W        = 5;
  localparam int         CH_W         = 11;
  localparam int         IDX_W        = 4;
  localparam int         CH_BASE_W    = 8;
  localparam int         FLAG_LSB     = (STORED_BYTES - 1) * 8;
  localparam int         NUM_CHANNELS = 16;
  localparam int         QUEUE_DEPTH  = 2;

  localparam int         CFG_IDX_W    = 4;
  localparam int         CFG_DATA_W   = CH_W;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_CHANNEL   = CFG_IDX_W'(1);

  localparam logic [CH_W-1:0]  THRESHOLD_RESET = CH_W'(1023);
  localparam logic [IDX_W-1:0] CHANNEL_RESET   = IDX_W'(7);

  typedef logic [FRAME_W-1:0] frame_t;

  typedef struct packed {
    logic   valid;
    frame_t data;
  } frame_push_t;

endpackage

@@ rtl/sbfd_front.sv @@
// ----------------------------------------------------------------------------
// sbfd_front
// Finds the start byte, collects the frame body and hands a complete frame
// to the queue when the end byte arrives.
// ----------------------------------------------------------------------------
module sbfd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [7:0]          in_rx_byte,
  output sbfd_pkg::frame_push_t push
);

  localparam logic [sbfd_pkg::POS_W-1:0] END_POS =
    sbfd_pkg::POS_W'(sbfd_pkg::FRAME_BYTES - 1);

  logic                         accept;
  logic                         in_frame_r;
  logic                         in_frame_nxt;
  logic [sbfd_pkg::POS_W-1:0]   pos_r;
  logic [sbfd_pkg::POS_W-1:0]   pos_nxt;
  sbfd_pkg::frame_t             frame_r;

  assign accept = in_valid && !in_stall;

  always_comb begin
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    if (accept) begin
      if (!in_frame_r) begin
        if (in_rx_byte == sbfd_pkg::START_BYTE) begin
          in_frame_nxt = 1'b1;
          pos_nxt      = sbfd_pkg::POS_W'(1);
        end
      end else if (pos_r != END_POS) begin
        pos_nxt = pos_r + sbfd_pkg::POS_W'(1);
      end else begin
        in_frame_nxt = 1'b0;
        pos_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      pos_r      <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      pos_r      <= pos_nxt;
    end
  end

  // Body bytes shift in from the top so that frame byte 1 ends at the bottom.
  always_ff @(posedge clk) begin
    if (accept && in_frame_r && pos_r != END_POS) begin
      frame_r <= {in_rx_byte, frame_r[sbfd_pkg::FRAME_W-1:8]};
    end
  end

  assign push.valid = accept && in_frame_r && (pos_r == END_POS);
  assign push.data  = frame_r;

endmodule

@@ rtl/sbfd_queue.sv @@
// ----------------------------------------------------------------------------
// sbfd_queue
// Short queue of complete frames between the front and the back.
// ----------------------------------------------------------------------------
module sbfd_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sbfd_pkg::frame_push_t push,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output sbfd_pkg::frame_t      head_data
);

  localparam int PTR_W = (sbfd_pkg::QUEUE_DEPTH > 1) ? $clog2(sbfd_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(sbfd_pkg::QUEUE_DEPTH + 1);

  sbfd_pkg::frame_t  entry_r [sbfd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push;
  logic              do_pop;

  assign full       = (count_r == CNT_W'(sbfd_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = entry_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(sbfd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(sbfd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/sbfd_back.sv @@
// ----------------------------------------------------------------------------
// sbfd_back
// Takes one frame at a time from the queue, decides the mode, toggles the
// frame parity and sends one channel result per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module sbfd_back #(
  parameter int NUM_CHANNELS = sbfd_pkg::NUM_CHANNELS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sbfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbfd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             head_valid,
  input  sbfd_pkg::frame_t                 head_data,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [sbfd_pkg::IDX_W-1:0]       out_channel_index,
  output logic [sbfd_pkg::CH_W-1:0]        out_channel_value,
  output logic                             out_digital_one,
  output logic                             out_digital_two,
  output logic                             out_frame_lost,
  output logic                             out_failsafe,
  output logic [7:0]                       out_flag_byte,
  output logic                             out_auto_mode,
  output logic                             out_frame_parity,
  output logic                             out_last_of_frame
);

  localparam logic [sbfd_pkg::IDX_W-1:0] LAST_IDX = sbfd_pkg::IDX_W'(NUM_CHANNELS - 1);

  logic [sbfd_pkg::CH_W-1:0]       threshold_r;
  logic [sbfd_pkg::IDX_W-1:0]      sel_channel_r;
  sbfd_pkg::frame_t                frm_r;
  logic                            busy_r;
  logic [sbfd_pkg::IDX_W-1:0]      cnt_r;
  logic                            mode_r;
  logic                            parity_r;
  logic                            out_valid_r;
  logic [sbfd_pkg::IDX_W-1:0]      out_idx_r;
  logic [sbfd_pkg::CH_W-1:0]       out_value_r;
  logic [7:0]                      out_flags_r;
  logic                            out_mode_r;
  logic                            out_parity_r;
  logic                            out_last_r;
  logic                            slot_free;
  logic                            emit;
  logic [sbfd_pkg::CH_BASE_W-1:0]  sel_base;
  logic [sbfd_pkg::CH_BASE_W-1:0]  cnt_base;
  logic [sbfd_pkg::CH_W-1:0]       sel_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r   <= sbfd_pkg::THRESHOLD_RESET;
      sel_channel_r <= sbfd_pkg::CHANNEL_RESET;
    end else if (cfg_we) begin
      if (cfg_index == sbfd_pkg::CFG_MODE_THRESHOLD) begin
        threshold_r <= cfg_wdata;
      end else if (cfg_index == sbfd_pkg::CFG_MODE_CHANNEL) begin
        sel_channel_r <= cfg_wdata[sbfd_pkg::IDX_W-1:0];
      end
    end
  end

  assign slot_free = !out_valid_r || !out_stall;
  assign pop       = !busy_r && head_valid;
  assign emit      = busy_r && slot_free;

  assign sel_base  = sbfd_pkg::CH_BASE_W'(sel_channel_r) *
                     sbfd_pkg::CH_BASE_W'(sbfd_pkg::CH_W);
  assign cnt_base  = sbfd_pkg::CH_BASE_W'(cnt_r) * sbfd_pkg::CH_BASE_W'(sbfd_pkg::CH_W);
  assign sel_value = head_data[sel_base +: sbfd_pkg::CH_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      mode_r      <= 1'b0;
      parity_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        busy_r   <= 1'b1;
        cnt_r    <= '0;
        mode_r   <= (sel_value >= threshold_r);
        parity_r <= ~parity_r;
      end else if (emit) begin
        if (cnt_r == LAST_IDX) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + sbfd_pkg::IDX_W'(1);
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (slot_free) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!pop && emit) begin
      frm_r        <= frm_r;
      out_idx_r    <= cnt_r;
      out_value_r  <= frm_r[cnt_base +: sbfd_pkg::CH_W];
      out_flags_r  <= frm_r[sbfd_pkg::FLAG_LSB +: 8];
      out_mode_r   <= mode_r;
      out_parity_r <= parity_r;
      out_last_r   <= (cnt_r == LAST_IDX);
    end else if (pop) begin
      frm_r <= head_data;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_channel_index = out_idx_r;
  assign out_channel_value = out_value_r;
  assign out_digital_one   = out_flags_r[0];
  assign out_digital_two   = out_flags_r[1];
  assign out_frame_lost    = out_flags_r[2];
  assign out_failsafe      = out_flags_r[3];
  assign out_flag_byte     = out_flags_r;
  assign out_auto_mode     = out_mode_r;
  assign out_frame_parity  = out_parity_r;
  assign out_last_of_frame = out_last_r;

endmodule

@@ rtl/sbus_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// SBUS frame decoder for sixteen proportional channels.
//
// Received bytes come in on the in_ channel, one per transfer. A 0x0f byte
// while idle opens a frame; the 24 bytes after it complete it. The end
// byte's value is not checked. The input takes one byte per cycle; in_stall
// rises only while two decoded frames wait in the frame queue.
// Each complete frame gives NUM_CHANNELS results on the out_ channel,
// channel 0 first, with out_last_of_frame on the final one. Each frame is
// queued, then loaded into the back's frame register, and its results are
// registered, one per cycle, as the emit stage's channel counter steps.
// While out_stall is high the shown result holds; the queue and the byte
// collector keep running until the queue fills.
// The cfg_ port writes mode_threshold (index 0) and mode_channel (index 1);
// write only while no frame is in flight. Reset clears the frame state, mode
// and parity, drops all queued frames and restores the register defaults.
// ----------------------------------------------------------------------------
module sbus_frame_decoder #(
  parameter int NUM_CHANNELS = sbfd_pkg::NUM_CHANNELS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_rx_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [sbfd_pkg::IDX_W-1:0]       out_channel_index,
  output logic [sbfd_pkg::CH_W-1:0]        out_channel_value,
  output logic                             out_digital_one,
  output logic                             out_digital_two,
  output logic                             out_frame_lost,
  output logic                             out_failsafe,
  output logic [7:0]                       out_flag_byte,
  output logic                             out_auto_mode,
  output logic                             out_frame_parity,
  output logic                             out_last_of_frame,
  input  logic                             cfg_we,
  input  logic [sbfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbfd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  sbfd_pkg::frame_push_t push;
  logic                  q_full;
  logic                  q_pop;
  logic                  q_valid;
  sbfd_pkg::frame_t      q_data;

  assign in_stall = q_full;

  sbfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .push       (push)
  );

  sbfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_data)
  );

  sbfd_back #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .head_valid        (q_valid),
    .head_data         (q_data),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_channel_index (out_channel_index),
    .out_channel_value (out_channel_value),
    .out_digital_one   (out_digital_one),
    .out_digital_two   (out_digital_two),
    .out_frame_lost    (out_frame_lost),
    .out_failsafe      (out_failsafe),
    .out_flag_byte     (out_flag_byte),
    .out_auto_mode     (out_auto_mode),
    .out_frame_parity  (out_frame_parity),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule
